>>> hw/rtl/pcsm_pkg.sv
// constants shared by the p-code stack machine step block
// sizes, opcode, opr subcode and fault codes; no dependencies
`default_nettype none
package pcsm_pkg;

	localparam int STACK_DEPTH = 512;
	localparam int CODE_ADDR_MAX = 2047;

	localparam logic [2:0] OP_LIT = 3'd0;
	localparam logic [2:0] OP_OPR = 3'd1;
	localparam logic [2:0] OP_LOD = 3'd2;
	localparam logic [2:0] OP_STO = 3'd3;
	localparam logic [2:0] OP_CAL = 3'd4;
	localparam logic [2:0] OP_INT = 3'd5;
	localparam logic [2:0] OP_JMP = 3'd6;
	localparam logic [2:0] OP_JPC = 3'd7;

	localparam logic [10:0] OPR_RET = 11'd0;
	localparam logic [10:0] OPR_NEG = 11'd1;
	localparam logic [10:0] OPR_ADD = 11'd2;
	localparam logic [10:0] OPR_SUB = 11'd3;
	localparam logic [10:0] OPR_MUL = 11'd4;
	localparam logic [10:0] OPR_DIV = 11'd5;
	localparam logic [10:0] OPR_ODD = 11'd6;
	localparam logic [10:0] OPR_EQ  = 11'd8;
	localparam logic [10:0] OPR_NE  = 11'd9;
	localparam logic [10:0] OPR_LT  = 11'd10;
	localparam logic [10:0] OPR_GE  = 11'd11;
	localparam logic [10:0] OPR_GT  = 11'd12;
	localparam logic [10:0] OPR_LE  = 11'd13;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_DIV0 = 2'd1;
	localparam logic [1:0] FAULT_WRAP = 2'd2;

endpackage
`default_nettype wire

>>> hw/rtl/pcode_stack_machine_step.sv
// p-code stack machine step: executes one instruction per input transaction
// depends on pcsm_pkg; stack held in a single-port-write, registered-read memory
// a divide by a nonzero value runs the iterative divider before its quotient is written;
//   a stalled result holds the block in its output state
// throughput: one instruction at a time; the next is accepted once the result is loaded into the output registers
// reset: after arst_n releases, a clearing pass writes zero to all 512 stack
//   words, one per cycle, before the first instruction is accepted
`default_nettype none
module pcode_stack_machine_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [1:0]  level,
	input  wire logic [10:0] operand,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [10:0]      next_pc,
	output logic [8:0]       base_ptr,
	output logic [8:0]       top_ptr,
	output logic signed [31:0] top_value,
	output logic             halted,
	output logic [1:0]       fault
);

	localparam int SW = $clog2(pcsm_pkg::STACK_DEPTH);
	localparam int PW = SW + 1;
	localparam int FW = 12;
	localparam int CW = $clog2(pcsm_pkg::CODE_ADDR_MAX + 1);
	localparam logic [PW-1:0] DEPTH = PW'(pcsm_pkg::STACK_DEPTH);
	localparam logic [CW-1:0] PC_MAX = CW'(pcsm_pkg::CODE_ADDR_MAX);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DEC, S_DIV,
		S_RET1, S_RET2, S_RET3,
		S_UN, S_BIN1, S_BIN2, S_BIN3,
		S_LOD2, S_STO2,
		S_CAL2, S_CAL3, S_JPC1,
		S_TRD, S_OUT
	} state_t;

	state_t state_q;
	logic [SW-1:0] clr_q, top_q, base_q, t_q;
	logic [CW-1:0] pc_q, npc_q;
	logic [2:0]    op_q;
	logic [10:0]   arg_q;
	logic          wrap_q, dz_q, neg_q;
	logic [31:0]   a_q, rd_q, dvd_q, dvs_q, rem_q, quo_q;
	logic [4:0]    cnt_q;
	logic          out_valid_q;

	logic [31:0] mem [pcsm_pkg::STACK_DEPTH];
	logic          mem_we, mem_re;
	logic [SW-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd;

	function automatic logic [SW:0] add_w(logic [SW-1:0] i, logic [1:0] k);
		logic [PW-1:0] s;
		s = {1'b0, i} + PW'(k);
		if (s >= DEPTH) begin
			return {1'b1, SW'(s - DEPTH)};
		end
		return {1'b0, s[SW-1:0]};
	endfunction

	function automatic logic [SW:0] sub1_w(logic [SW-1:0] i);
		if (i == '0) begin
			return {1'b1, SW'(DEPTH - PW'(1))};
		end
		return {1'b0, i - SW'(1)};
	endfunction

	logic [SW:0] tp1_w, tm1_w, bm1_w, tq1_w, tq2_w, tq3_w;
	logic [FW-1:0] fsum;
	logic [SW-1:0] fidx;
	logic fflag, is_bin, out_load;
	logic [31:0] bin_res, un_res, a_mag, b_mag;
	logic [32:0] r2;
	logic [33:0] diff;

	assign tp1_w = add_w(top_q, 2'd1);
	assign tm1_w = sub1_w(top_q);
	assign bm1_w = sub1_w(base_q);
	assign tq1_w = add_w(t_q, 2'd1);
	assign tq2_w = add_w(t_q, 2'd2);
	assign tq3_w = add_w(t_q, 2'd3);
	assign fsum = FW'(op_q == pcsm_pkg::OP_INT ? top_q : base_q) + FW'(arg_q);
	assign fidx = fsum[SW-1:0];
	assign fflag = (fsum[FW-1:SW] != '0);
	assign is_bin = (arg_q >= pcsm_pkg::OPR_ADD && arg_q <= pcsm_pkg::OPR_DIV) ||
		(arg_q >= pcsm_pkg::OPR_EQ && arg_q <= pcsm_pkg::OPR_LE);
	assign a_mag = a_q[31] ? (~a_q) + 32'd1 : a_q;
	assign b_mag = rd_q[31] ? (~rd_q) + 32'd1 : rd_q;
	assign r2 = {rem_q, dvd_q[31]};
	assign diff = {1'b0, r2} - {2'b00, dvs_q};
	assign un_res = (arg_q == pcsm_pkg::OPR_NEG) ? (~rd_q) + 32'd1 :
		(!rd_q[0] ? 32'd0 : (rd_q[31] ? 32'hFFFF_FFFF : 32'd1));
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		case (arg_q)
			pcsm_pkg::OPR_ADD: bin_res = a_q + rd_q;
			pcsm_pkg::OPR_SUB: bin_res = a_q - rd_q;
			pcsm_pkg::OPR_MUL: bin_res = 32'(a_q * rd_q);
			pcsm_pkg::OPR_EQ:  bin_res = 32'($signed(a_q) == $signed(rd_q));
			pcsm_pkg::OPR_NE:  bin_res = 32'($signed(a_q) != $signed(rd_q));
			pcsm_pkg::OPR_LT:  bin_res = 32'($signed(a_q) < $signed(rd_q));
			pcsm_pkg::OPR_GE:  bin_res = 32'($signed(a_q) >= $signed(rd_q));
			pcsm_pkg::OPR_GT:  bin_res = 32'($signed(a_q) > $signed(rd_q));
			pcsm_pkg::OPR_LE:  bin_res = 32'($signed(a_q) <= $signed(rd_q));
			default:           bin_res = 32'd0;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = top_q;
		mem_wd = rd_q;
		mem_re = 1'b0;
		mem_ra = top_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = 32'd0;
			end
			S_DEC: begin
				case (op_q)
					pcsm_pkg::OP_LIT: begin
						mem_we = 1'b1;
						mem_wa = tp1_w[SW-1:0];
						mem_wd = 32'(arg_q);
					end
					pcsm_pkg::OP_OPR: begin
						if (arg_q == pcsm_pkg::OPR_NEG || arg_q == pcsm_pkg::OPR_ODD) begin
							mem_re = 1'b1;
						end else if (is_bin) begin
							mem_re = 1'b1;
							mem_ra = tm1_w[SW-1:0];
						end
					end
					pcsm_pkg::OP_LOD: begin
						mem_re = 1'b1;
						mem_ra = fidx;
					end
					pcsm_pkg::OP_STO: mem_re = 1'b1;
					pcsm_pkg::OP_CAL: begin
						mem_we = 1'b1;
						mem_wa = tp1_w[SW-1:0];
						mem_wd = 32'(base_q);
					end
					pcsm_pkg::OP_JPC: mem_re = 1'b1;
					default: ;
				endcase
			end
			S_RET1: begin
				mem_re = 1'b1;
				mem_ra = tq3_w[SW-1:0];
			end
			S_RET2: begin
				mem_re = 1'b1;
				mem_ra = tq2_w[SW-1:0];
			end
			S_UN: begin
				mem_we = 1'b1;
				mem_wd = un_res;
			end
			S_BIN1: begin
				mem_re = 1'b1;
				mem_ra = tq1_w[SW-1:0];
			end
			S_BIN2: begin
				if (arg_q != pcsm_pkg::OPR_DIV || rd_q == '0) begin
					mem_we = 1'b1;
					mem_wa = t_q;
					mem_wd = bin_res;
				end
			end
			S_BIN3: begin
				mem_we = 1'b1;
				mem_wa = t_q;
				mem_wd = neg_q ? (~quo_q) + 32'd1 : quo_q;
			end
			S_LOD2: begin
				mem_we = 1'b1;
				mem_wa = tp1_w[SW-1:0];
			end
			S_STO2: begin
				mem_we = 1'b1;
				mem_wa = t_q;
			end
			S_CAL2: begin
				mem_we = 1'b1;
				mem_wa = tq2_w[SW-1:0];
				mem_wd = 32'(base_q);
			end
			S_CAL3: begin
				mem_we = 1'b1;
				mem_wa = tq3_w[SW-1:0];
				mem_wd = 32'(npc_q);
			end
			S_TRD: mem_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			pc_q <= '0;
			npc_q <= '0;
			base_q <= '0;
			top_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(DEPTH - PW'(1))) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						arg_q <= operand;
						npc_q <= (pc_q == PC_MAX) ? '0 : pc_q + CW'(1);
						wrap_q <= 1'b0;
						dz_q <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_TRD;
					case (op_q)
						pcsm_pkg::OP_LIT: begin
							top_q <= tp1_w[SW-1:0];
							wrap_q <= tp1_w[SW];
						end
						pcsm_pkg::OP_OPR: begin
							if (arg_q == pcsm_pkg::OPR_RET) begin
								t_q <= bm1_w[SW-1:0];
								wrap_q <= bm1_w[SW];
								state_q <= S_RET1;
							end else if (arg_q == pcsm_pkg::OPR_NEG ||
								arg_q == pcsm_pkg::OPR_ODD) begin
								state_q <= S_UN;
							end else if (is_bin) begin
								t_q <= tm1_w[SW-1:0];
								wrap_q <= tm1_w[SW];
								state_q <= S_BIN1;
							end
						end
						pcsm_pkg::OP_LOD: begin
							wrap_q <= fflag;
							state_q <= S_LOD2;
						end
						pcsm_pkg::OP_STO: begin
							t_q <= fidx;
							wrap_q <= fflag;
							state_q <= S_STO2;
						end
						pcsm_pkg::OP_INT: begin
							top_q <= fidx;
							wrap_q <= fflag;
						end
						pcsm_pkg::OP_CAL: begin
							t_q <= top_q;
							wrap_q <= tp1_w[SW];
							state_q <= S_CAL2;
						end
						pcsm_pkg::OP_JMP: npc_q <= arg_q[CW-1:0];
						default: state_q <= S_JPC1;
					endcase
				end
				S_DIV: begin
					if (!diff[33]) begin
						rem_q <= diff[31:0];
					end else begin
						rem_q <= r2[31:0];
					end
					quo_q <= {quo_q[30:0], !diff[33]};
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_BIN3;
					end
				end
				S_RET1: begin
					wrap_q <= wrap_q | tq3_w[SW];
					state_q <= S_RET2;
				end
				S_RET2: begin
					npc_q <= rd_q[CW-1:0];
					wrap_q <= wrap_q | tq2_w[SW];
					state_q <= S_RET3;
				end
				S_RET3: begin
					base_q <= rd_q[SW-1:0];
					wrap_q <= wrap_q | (rd_q[31:SW] != '0);
					top_q <= t_q;
					state_q <= S_TRD;
				end
				S_UN: state_q <= S_TRD;
				S_BIN1: begin
					a_q <= rd_q;
					wrap_q <= wrap_q | tq1_w[SW];
					state_q <= S_BIN2;
				end
				S_BIN2: begin
					top_q <= t_q;
					state_q <= S_TRD;
					if (arg_q == pcsm_pkg::OPR_DIV) begin
						if (rd_q == '0) begin
							dz_q <= 1'b1;
						end else begin
							neg_q <= a_q[31] ^ rd_q[31];
							dvd_q <= a_mag;
							dvs_q <= b_mag;
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_BIN3: state_q <= S_TRD;
				S_LOD2: begin
					top_q <= tp1_w[SW-1:0];
					wrap_q <= wrap_q | tp1_w[SW];
					state_q <= S_TRD;
				end
				S_STO2: begin
					top_q <= tm1_w[SW-1:0];
					wrap_q <= wrap_q | tm1_w[SW];
					state_q <= S_TRD;
				end
				S_CAL2: begin
					wrap_q <= wrap_q | tq2_w[SW];
					state_q <= S_CAL3;
				end
				S_CAL3: begin
					wrap_q <= wrap_q | tq3_w[SW];
					base_q <= tq1_w[SW-1:0];
					npc_q <= arg_q[CW-1:0];
					state_q <= S_TRD;
				end
				S_JPC1: begin
					top_q <= tm1_w[SW-1:0];
					wrap_q <= wrap_q | tm1_w[SW];
					state_q <= S_TRD;
					if (rd_q == '0) begin
						npc_q <= arg_q[CW-1:0];
					end
				end
				S_TRD: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						pc_q <= npc_q;
						next_pc <= 11'(npc_q);
						base_ptr <= 9'(base_q);
						top_ptr <= 9'(top_q);
						top_value <= $signed(rd_q);
						halted <= (npc_q == '0);
						fault <= dz_q ? pcsm_pkg::FAULT_DIV0 :
							(wrap_q ? pcsm_pkg::FAULT_WRAP : pcsm_pkg::FAULT_NONE);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE) || (level == 2'd0 && 1'b0);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> verif/tb_pcode_stack_machine_step.sv
// testbench for pcode_stack_machine_step: directed and random instruction streams
// checked against an in-bench model of the p-code machine; depends on pcsm_pkg
`timescale 1ns / 1ps
module tb_pcode_stack_machine_step;

	localparam int DEPTH = 512;
	localparam int PC_MAX = 2047;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [1:0]  level;
		logic [10:0] operand;
	} instr_t;

	typedef struct packed {
		logic [10:0]        next_pc;
		logic [8:0]         base_ptr;
		logic [8:0]         top_ptr;
		logic signed [31:0] top_value;
		logic               halted;
		logic [1:0]         fault;
	} machine_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [1:0] level = '0;
	logic [10:0] operand = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [10:0] next_pc;
	logic [8:0] base_ptr;
	logic [8:0] top_ptr;
	logic signed [31:0] top_value;
	logic halted;
	logic [1:0] fault;

	instr_t pending_instrs[$];
	machine_state_t expected_states[$];
	int errors = 0;
	int n_items = 0;
	int n_done = 0;
	bit in_taken = 1'b0;
	bit no_idle = 1'b0;

	// machine model
	logic [31:0] mem[DEPTH];
	int m_pc, m_base, m_top;
	logic [1:0] m_fault;

	pcode_stack_machine_step u_top (.*);

	always #4 clk = ~clk;

	function automatic int wrap(longint v);
		longint r;
		r = v % DEPTH;
		if (r < 0)
			r += DEPTH;
		if (r != v && m_fault == pcsm_pkg::FAULT_NONE)
			m_fault = pcsm_pkg::FAULT_WRAP;
		return int'(r);
	endfunction

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	task automatic exec_instr(instr_t ins);
		int pc, t, i;
		logic [31:0] x, y, r;
		longint a, b;
		machine_state_t s;
		m_fault = pcsm_pkg::FAULT_NONE;
		pc = (m_pc + 1 > PC_MAX) ? 0 : m_pc + 1;
		t = m_top;
		case (ins.opcode)
			pcsm_pkg::OP_LIT: begin
				t = wrap(t + 1);
				mem[t] = 32'(ins.operand);
				m_top = t;
			end
			pcsm_pkg::OP_OPR: begin
				if (ins.operand == pcsm_pkg::OPR_RET) begin
					t = wrap(longint'(m_base) - 1);
					pc = int'(mem[wrap(t + 3)] % (PC_MAX + 1));
					m_base = wrap(sx(mem[wrap(t + 2)]));
					m_top = t;
				end else if (ins.operand == pcsm_pkg::OPR_NEG) begin
					mem[t] = -mem[t];
				end else if (ins.operand == pcsm_pkg::OPR_ODD) begin
					mem[t] = 32'(sx(mem[t]) % 2);
				end else if (ins.operand >= pcsm_pkg::OPR_ADD && ins.operand <= pcsm_pkg::OPR_LE
						&& ins.operand != 11'd7) begin
					t = wrap(t - 1);
					x = mem[t];
					y = mem[wrap(t + 1)];
					a = sx(x);
					b = sx(y);
					case (ins.operand)
						pcsm_pkg::OPR_ADD: r = x + y;
						pcsm_pkg::OPR_SUB: r = x - y;
						pcsm_pkg::OPR_MUL: r = x * y;
						pcsm_pkg::OPR_DIV: begin
							if (b == 0) begin
								r = '0;
								m_fault = pcsm_pkg::FAULT_DIV0;
							end else if (x == 32'h8000_0000 && b == -1)
								r = 32'h8000_0000;
							else
								r = 32'(a / b);
						end
						pcsm_pkg::OPR_EQ: r = 32'(a == b);
						pcsm_pkg::OPR_NE: r = 32'(a != b);
						pcsm_pkg::OPR_LT: r = 32'(a < b);
						pcsm_pkg::OPR_GE: r = 32'(a >= b);
						pcsm_pkg::OPR_GT: r = 32'(a > b);
						default: r = 32'(a <= b);
					endcase
					mem[t] = r;
					m_top = t;
				end
			end
			pcsm_pkg::OP_LOD: begin
				t = wrap(t + 1);
				mem[t] = mem[wrap(m_base + ins.operand)];
				m_top = t;
			end
			pcsm_pkg::OP_STO: begin
				mem[wrap(m_base + ins.operand)] = mem[t];
				m_top = wrap(t - 1);
			end
			pcsm_pkg::OP_CAL: begin
				mem[wrap(t + 1)] = 32'(m_base);
				mem[wrap(t + 2)] = 32'(m_base);
				mem[wrap(t + 3)] = 32'(pc);
				m_base = wrap(t + 1);
				pc = ins.operand % (PC_MAX + 1);
			end
			pcsm_pkg::OP_INT: m_top = wrap(t + ins.operand);
			pcsm_pkg::OP_JMP: pc = ins.operand % (PC_MAX + 1);
			default: begin
				if (mem[t] == 0)
					pc = ins.operand % (PC_MAX + 1);
				m_top = wrap(t - 1);
			end
		endcase
		m_pc = pc;
		s.next_pc = 11'(m_pc);
		s.base_ptr = 9'(m_base);
		s.top_ptr = 9'(m_top);
		s.top_value = mem[m_top];
		s.halted = (m_pc == 0);
		s.fault = m_fault;
		expected_states.push_back(s);
	endtask

	function automatic instr_t mk(logic [2:0] op, logic [10:0] arg);
		instr_t i;
		i.opcode = op;
		i.level = 2'($urandom_range(0, 3));
		i.operand = arg;
		return i;
	endfunction

	function automatic instr_t rand_instr();
		int k;
		k = $urandom_range(0, 99);
		if (k < 30)
			return mk(pcsm_pkg::OP_LIT, ($urandom_range(0, 3) == 0) ? 11'($urandom) :
				11'($urandom_range(0, 20)));
		if (k < 60)
			return mk(pcsm_pkg::OP_OPR, ($urandom_range(0, 19) == 0) ? 11'($urandom) :
				11'($urandom_range(1, 13)));
		if (k < 70)
			return mk(pcsm_pkg::OP_LOD, 11'($urandom_range(0, 8)));
		if (k < 78)
			return mk(pcsm_pkg::OP_STO, 11'($urandom_range(0, 8)));
		if (k < 82)
			return mk(pcsm_pkg::OP_CAL, 11'($urandom));
		if (k < 85)
			return mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_RET);
		if (k < 91)
			return mk(pcsm_pkg::OP_INT, ($urandom_range(0, 9) == 0) ? 11'($urandom) :
				11'($urandom_range(0, 4)));
		if (k < 95)
			return mk(pcsm_pkg::OP_JMP, 11'($urandom));
		return mk(pcsm_pkg::OP_JPC, 11'($urandom));
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_instrs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
					instr_t i;
					i = pending_instrs.pop_front();
					in_valid <= 1'b1;
					opcode <= i.opcode;
					level <= i.level;
					operand <= i.operand;
				end else
					in_valid <= 1'b0;
			end
			out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 33);
		end
	end

	// model update at acceptance
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken)
			exec_instr(instr_t'({opcode, level, operand}));
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_done++;
			if (expected_states.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction pc=%0d", $time, next_pc);
			end else begin
				machine_state_t e;
				e = expected_states.pop_front();
				if (e.next_pc !== next_pc) begin
					errors++;
					$display("%0t: next_pc exp %0d got %0d", $time, e.next_pc, next_pc);
				end
				if (e.base_ptr !== base_ptr) begin
					errors++;
					$display("%0t: base_ptr exp %0d got %0d", $time, e.base_ptr, base_ptr);
				end
				if (e.top_ptr !== top_ptr) begin
					errors++;
					$display("%0t: top_ptr exp %0d got %0d", $time, e.top_ptr, top_ptr);
				end
				if (e.top_value !== top_value) begin
					errors++;
					$display("%0t: top_value exp %0d got %0d", $time, e.top_value, top_value);
				end
				if (e.halted !== halted) begin
					errors++;
					$display("%0t: halted exp %0d got %0d", $time, e.halted, halted);
				end
				if (e.fault !== fault) begin
					errors++;
					$display("%0t: fault exp %0d got %0d", $time, e.fault, fault);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		foreach (mem[i])
			mem[i] = '0;
		m_pc = 0;
		m_base = 0;
		m_top = 0;
		// directed
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'h7FF));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd0));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_DIV));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_NEG));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd3));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_ODD));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd5));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_MUL));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_SUB));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd7));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_ADD));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, 11'd7));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, 11'h7FF));
		for (int c = pcsm_pkg::OPR_EQ; c <= pcsm_pkg::OPR_LE; c++) begin
			pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd2));
			pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, 11'(c)));
		end
		// minimum word divided by minus one
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd1024));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd1024));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_MUL));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd1024));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_MUL));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd2));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_MUL));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LIT, 11'd1));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_NEG));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_DIV));
		pending_instrs.push_back(mk(pcsm_pkg::OP_STO, 11'd1));
		pending_instrs.push_back(mk(pcsm_pkg::OP_LOD, 11'h7FF));
		pending_instrs.push_back(mk(pcsm_pkg::OP_CAL, 11'h7FF));
		pending_instrs.push_back(mk(pcsm_pkg::OP_INT, 11'h7FF));
		pending_instrs.push_back(mk(pcsm_pkg::OP_OPR, pcsm_pkg::OPR_RET));
		pending_instrs.push_back(mk(pcsm_pkg::OP_JPC, 11'd0));
		pending_instrs.push_back(mk(pcsm_pkg::OP_JMP, 11'h7FF));
		for (int i = 0; i < 2000; i++)
			pending_instrs.push_back(rand_instr());
		n_items = pending_instrs.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_instrs.size() < 1200);
		no_idle = 1'b1;
		wait (pending_instrs.size() < 800);
		no_idle = 1'b0;
		wait (n_done >= n_items);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_states.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
